// ===== rtl/core/tlf_pkg.sv =====
// ----------------------------------------------------------------------------
// tlf_pkg
// shared constants and types of the text line folder: widths, character
// codes, register indexes and the structs passed between its modules
// ----------------------------------------------------------------------------
`default_nettype none

package tlf_pkg;

    // line buffer geometry
    localparam int MAX_COLUMNS = 32;
    localparam int IDX_W       = $clog2(MAX_COLUMNS);
    localparam int CNT_W       = 6;

    // characters handled specially
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_BLANK = 8'd32;

    // configuration register file
    localparam int          CFG_ADDR_W = 3;
    localparam int          CFG_DATA_W = 32;
    localparam logic        REG_FOLD   = 1'b0;
    localparam logic        REG_TAB    = 1'b1;
    localparam logic [5:0]  FOLD_RESET = 6'd20;
    localparam logic [5:0]  TAB_RESET  = 6'd6;
    localparam logic [5:0]  FOLD_MIN   = 6'd2;
    localparam logic [5:0]  FOLD_MAX   = 6'(MAX_COLUMNS);
    localparam logic [5:0]  TAB_MIN    = 6'd1;

    // effective settings seen by the folding core
    typedef struct packed {
        logic [CNT_W-1:0] fold;
        logic [CNT_W-1:0] tab;
    } t_cfg;

    // one output beat offered by the core
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_emit;

endpackage

`default_nettype wire

// ===== rtl/core/tlf_cfg.sv =====
// ----------------------------------------------------------------------------
// tlf_cfg
// apb register file holding fold column and tab width, with the clamping
// of out-of-range values applied on the way to the core
// ----------------------------------------------------------------------------
`default_nettype none

module tlf_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tlf_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [tlf_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [tlf_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output tlf_pkg::t_cfg                         o_cfg
);

    logic [tlf_pkg::CNT_W-1:0] r_fold;
    logic [tlf_pkg::CNT_W-1:0] r_tab;
    logic                      wr_en;
    logic                      reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold <= tlf_pkg::FOLD_RESET;
            r_tab  <= tlf_pkg::TAB_RESET;
        end else if (wr_en) begin
            if (reg_sel == tlf_pkg::REG_FOLD) begin
                r_fold <= pwdata[tlf_pkg::CNT_W-1:0];
            end else begin
                r_tab <= pwdata[tlf_pkg::CNT_W-1:0];
            end
        end
    end

    // read back raw values
    always_comb begin
        prdata = '0;
        if (reg_sel == tlf_pkg::REG_FOLD) begin
            prdata[tlf_pkg::CNT_W-1:0] = r_fold;
        end else begin
            prdata[tlf_pkg::CNT_W-1:0] = r_tab;
        end
    end

    // clamp to the usable range
    always_comb begin
        if (r_fold < tlf_pkg::FOLD_MIN) begin
            o_cfg.fold = tlf_pkg::FOLD_MIN;
        end else if (r_fold > tlf_pkg::FOLD_MAX) begin
            o_cfg.fold = tlf_pkg::FOLD_MAX;
        end else begin
            o_cfg.fold = r_fold;
        end
        o_cfg.tab = (r_tab == '0) ? tlf_pkg::TAB_MIN : r_tab;
    end

endmodule

`default_nettype wire

// ===== rtl/core/tlf_core.sv =====
// ----------------------------------------------------------------------------
// tlf_core
// line buffer memory and the sequencer that stores bytes, expands tabs,
// searches for the break blank, emits lines and moves the tail to the front
// ----------------------------------------------------------------------------
`default_nettype none

module tlf_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_valid,
    output logic               o_s_ready,
    input  wire logic [7:0]    i_s_byte,
    input  wire tlf_pkg::t_cfg i_cfg,
    output tlf_pkg::t_emit     o_emit,
    input  wire logic          i_emit_ready
);

    localparam int CW = tlf_pkg::CNT_W;
    localparam int IW = tlf_pkg::IDX_W;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MOD      = 4'd1;
    localparam logic [3:0] ST_TAB      = 4'd2;
    localparam logic [3:0] ST_EMIT_RD  = 4'd3;
    localparam logic [3:0] ST_EMIT_WR  = 4'd4;
    localparam logic [3:0] ST_EMIT_NL  = 4'd5;
    localparam logic [3:0] ST_SRCH_RD  = 4'd6;
    localparam logic [3:0] ST_SRCH_CMP = 4'd7;
    localparam logic [3:0] ST_SHIFT_RD = 4'd8;
    localparam logic [3:0] ST_SHIFT_WR = 4'd9;

    localparam logic [CW-1:0] CNT_TOP = CW'(tlf_pkg::MAX_COLUMNS - 1);

    // line buffer, one write and one registered read port
    logic [7:0]    mem [tlf_pkg::MAX_COLUMNS];
    logic [7:0]    r_rd_data;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic          mem_re;
    logic [IW-1:0] mem_ra;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;   // committed line fill
    logic [CW-1:0] r_idx,   n_idx;     // write, emit or shift pointer
    logic [CW-1:0] r_ph,    n_ph;      // position within the tab stop
    logic [CW-1:0] r_len,   n_len;     // length of the line being emitted
    logic [CW-1:0] r_cnt,   n_cnt;     // fill at the time of a fold
    logic [IW-1:0] r_b,     n_b;       // blank search position
    logic          r_post,  n_post;    // move the tail after the emit

    logic          s_fire;
    logic [CW-1:0] cnt_in;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] ph_inc;
    logic [CW-1:0] rem;
    logic [CW-1:0] src;

    assign o_s_ready = (r_state == ST_IDLE);
    assign s_fire    = i_s_valid && o_s_ready;
    assign cnt_in    = (r_count > CNT_TOP) ? CNT_TOP : r_count;
    assign cnt_inc   = cnt_in + CW'(1);
    assign idx_inc   = r_idx + CW'(1);
    assign ph_inc    = (r_ph + CW'(1) == i_cfg.tab) ? '0 : r_ph + CW'(1);
    assign rem       = r_cnt - r_len;
    assign src       = r_len + r_idx;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_ph    = r_ph;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_b     = r_b;
        n_post  = r_post;
        mem_we  = 1'b0;
        mem_wa  = r_idx[IW-1:0];
        mem_wd  = tlf_pkg::CH_BLANK;
        mem_re  = 1'b0;
        mem_ra  = r_idx[IW-1:0];
        o_emit  = '0;

        case (r_state)
            ST_IDLE: begin
                if (s_fire) begin
                    if (i_s_byte == tlf_pkg::CH_TAB) begin
                        n_idx   = cnt_in;
                        n_ph    = cnt_in;
                        n_state = ST_MOD;
                    end else if (i_s_byte == tlf_pkg::CH_NL) begin
                        n_len   = cnt_in;
                        n_idx   = '0;
                        n_post  = 1'b0;
                        n_state = ST_EMIT_RD;
                    end else begin
                        mem_we = 1'b1;
                        mem_wa = cnt_in[IW-1:0];
                        mem_wd = i_s_byte;
                        if (cnt_inc >= i_cfg.fold) begin
                            n_cnt   = cnt_inc;
                            n_b     = cnt_in[IW-1:0];
                            n_state = ST_SRCH_RD;
                        end else begin
                            n_count = cnt_inc;
                        end
                    end
                end
            end
            // column modulo tab width by repeated subtraction
            ST_MOD: begin
                if (r_ph >= i_cfg.tab) begin
                    n_ph = r_ph - i_cfg.tab;
                end else begin
                    n_state = ST_TAB;
                end
            end
            // one blank per cycle up to the next stop or the fold column
            ST_TAB: begin
                mem_we = 1'b1;
                mem_wa = r_idx[IW-1:0];
                mem_wd = tlf_pkg::CH_BLANK;
                if (idx_inc < i_cfg.fold && ph_inc != '0) begin
                    n_idx = idx_inc;
                    n_ph  = ph_inc;
                end else if (idx_inc >= i_cfg.fold) begin
                    n_len   = idx_inc;
                    n_idx   = '0;
                    n_post  = 1'b0;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_count = idx_inc;
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                if (r_idx == r_len) begin
                    n_state = ST_EMIT_NL;
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = r_idx[IW-1:0];
                    n_state = ST_EMIT_WR;
                end
            end
            ST_EMIT_WR: begin
                o_emit.valid = 1'b1;
                o_emit.data  = r_rd_data;
                if (i_emit_ready) begin
                    n_idx   = idx_inc;
                    n_state = ST_EMIT_RD;
                end
            end
            ST_EMIT_NL: begin
                o_emit.valid = 1'b1;
                o_emit.data  = tlf_pkg::CH_NL;
                o_emit.last  = 1'b1;
                if (i_emit_ready) begin
                    n_idx = '0;
                    if (r_post) begin
                        n_state = ST_SHIFT_RD;
                    end else begin
                        n_count = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            // walk back from the last filled entry looking for a blank
            ST_SRCH_RD: begin
                if (r_b == '0) begin
                    n_len   = r_cnt;
                    n_idx   = '0;
                    n_post  = 1'b0;
                    n_state = ST_EMIT_RD;
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = r_b;
                    n_state = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                if (r_rd_data == tlf_pkg::CH_BLANK) begin
                    n_len   = {1'b0, r_b} + CW'(1);
                    n_idx   = '0;
                    n_post  = 1'b1;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_b     = r_b - IW'(1);
                    n_state = ST_SRCH_RD;
                end
            end
            // move the unbroken tail to the front
            ST_SHIFT_RD: begin
                if (r_idx == rem) begin
                    n_count = rem;
                    n_state = ST_IDLE;
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = src[IW-1:0];
                    n_state = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                mem_we  = 1'b1;
                mem_wa  = r_idx[IW-1:0];
                mem_wd  = r_rd_data;
                n_idx   = idx_inc;
                n_state = ST_SHIFT_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_ph   <= n_ph;
        r_len  <= n_len;
        r_cnt  <= n_cnt;
        r_b    <= n_b;
        r_post <= n_post;
    end

    // line buffer access
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= mem[mem_ra];
        end
    end

    // the line fill never reaches the buffer depth between items
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_TOP)
        else $error("line fill out of range");

    // the closing newline ends the emit and leads only to idle or the tail move
    a_nl_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.valid && o_emit.last && i_emit_ready)
        |=> (r_state == ST_IDLE || r_state == ST_SHIFT_RD))
        else $error("bad state after newline");

    // emit pointer stays within the line being emitted
    a_emit_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_RD) |-> (r_idx <= r_len))
        else $error("emit pointer beyond line length");

    // tail move reads only entries that were filled
    a_shift_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT_RD) |-> (r_len + r_idx <= r_cnt))
        else $error("tail move source beyond fill");

endmodule

`default_nettype wire

// ===== rtl/core/text_line_folder_unit.sv =====
// ----------------------------------------------------------------------------
// text_line_folder_unit
// folds a byte stream into lines no longer than the fold column
// ----------------------------------------------------------------------------
// Bytes enter on the s_ stream one beat at a time; folded text leaves on the
// m_ stream, m_tlast marking the final beat caused by one input byte (always
// a newline). fold_column and tab_width are set over the apb port and read
// back raw; the user must set them only while the block is idle, which the
// block itself does not enforce. The sequencer works around the line buffer
// with its one write and one registered read port: an ordinary byte that
// does not fold is stored as it is accepted; a tab first reduces the column
// modulo tab_width by repeated subtraction, then writes one blank per step;
// an emitted line reads and sends each stored byte, then the newline; the
// blank search reads and compares each probed entry, and the tail move
// reads and writes each moved byte. s_tready is low from the accept until
// the item is done. An output register sits between the core and m_; when
// the receiver stalls, the sequencer holds at the pending beat. Reset clears
// the line fill and the state and restores fold 20 and tab width 6; the
// buffer itself needs no clearing and the block is ready right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_folder_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] in_byte
    // output stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [7:0]                       m_tdata,   // [7:0] out_byte
    output logic                                  m_tlast,
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [tlf_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [tlf_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [tlf_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready
);

    tlf_pkg::t_cfg  cfg;
    tlf_pkg::t_emit emit;
    logic           emit_ready;
    logic           r_m_valid;
    logic [7:0]     r_m_data;
    logic           r_m_last;

    tlf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tlf_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_tvalid),
        .o_s_ready    (s_tready),
        .i_s_byte     (s_tdata),
        .i_cfg        (cfg),
        .o_emit       (emit),
        .i_emit_ready (emit_ready)
    );

    // output register takes a new beat when empty or being drained
    assign emit_ready = !r_m_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (emit.valid && emit_ready) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid && emit_ready) begin
            r_m_data <= emit.data;
            r_m_last <= emit.last;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tlast  = r_m_last;

endmodule

`default_nettype wire

// ===== tb/sv/text_line_folder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// text_line_folder_unit_tb
// self-checking bench for the text line folder
// ----------------------------------------------------------------------------
// A clocked driver feeds bytes from a pending queue onto the s_ stream. Every
// accepted byte runs through a behavioral folding predictor that fills a
// queue of expected output beats. A clocked monitor pops the oldest one for
// each m_ beat and compares data and tlast. The run starts with a short
// directed sequence covering tabs, newlines, byte extremes, clamped fold and
// tab settings and a fold column lowered in mid-line. It then goes through
// random phases with different settings and sender and receiver idling.
// Settings are written over apb only once the block has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_folder_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT   = 3000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 37;
    localparam int SHOWN_ERRORS  = 10;

    localparam logic [tlf_pkg::CFG_ADDR_W-1:0] FOLD_ADDR = {tlf_pkg::REG_FOLD, 2'b00};
    localparam logic [tlf_pkg::CFG_ADDR_W-1:0] TAB_ADDR  = {tlf_pkg::REG_TAB, 2'b00};

    // one folded output beat
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_folded_beat;

    logic                           i_clk    = 1'b0;
    logic                           i_rst_n  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [7:0]                     m_tdata;
    logic                           m_tlast;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [tlf_pkg::CFG_ADDR_W-1:0] paddr    = '0;
    logic [tlf_pkg::CFG_DATA_W-1:0] pwdata   = '0;
    logic [tlf_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    // stimulus and expectations
    logic [7:0]    pending_bytes [$];
    t_folded_beat  expected_text [$];
    int unsigned   send_idle_pct  = 0;
    int unsigned   recv_stall_pct = 0;
    int unsigned   mismatches     = 0;
    int unsigned   beats_seen     = 0;
    int unsigned   stall_cycles   = 0;

    // predictor state: line buffer, fill and raw register copies
    logic [7:0] line_buf [tlf_pkg::MAX_COLUMNS];
    logic [5:0] line_fill = '0;
    logic [5:0] cfg_fold  = tlf_pkg::FOLD_RESET;
    logic [5:0] cfg_tab   = tlf_pkg::TAB_RESET;

    text_line_folder_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // push buffer entries 0..len-1 and a newline
    task automatic queue_line(input int unsigned len);
        for (int i = 0; i < len; i++) begin
            expected_text.push_back('{ch: line_buf[i], last: 1'b0});
        end
        expected_text.push_back('{ch: tlf_pkg::CH_NL, last: 1'b0});
    endtask

    // folding predictor, run once per accepted byte
    task automatic fold_predict(input logic [7:0] ch);
        int unsigned  fold_eff;
        int unsigned  tab_eff;
        int unsigned  fill;
        int unsigned  brk;
        int unsigned  rest;
        int unsigned  first_new;
        t_folded_beat tail;
        first_new = expected_text.size();
        fold_eff  = (cfg_fold < tlf_pkg::FOLD_MIN) ? tlf_pkg::FOLD_MIN :
                    (cfg_fold > tlf_pkg::FOLD_MAX) ? tlf_pkg::FOLD_MAX : cfg_fold;
        tab_eff   = (cfg_tab == 0) ? tlf_pkg::TAB_MIN : cfg_tab;
        fill      = line_fill;
        if (fill >= tlf_pkg::MAX_COLUMNS) fill = tlf_pkg::MAX_COLUMNS - 1;
        if (ch == tlf_pkg::CH_TAB) begin
            // blanks up to the next tab stop, flush if the fold is reached
            line_buf[fill] = tlf_pkg::CH_BLANK;
            fill++;
            while (fill < fold_eff && (fill % tab_eff) != 0) begin
                line_buf[fill] = tlf_pkg::CH_BLANK;
                fill++;
            end
            if (fill >= fold_eff) begin
                queue_line(fill);
                fill = 0;
            end
        end else if (ch == tlf_pkg::CH_NL) begin
            queue_line(fill);
            fill = 0;
        end else begin
            line_buf[fill] = ch;
            fill++;
            if (fill >= fold_eff) begin
                // break after the last blank past the first column
                brk = fill - 1;
                while (brk > 0 && line_buf[brk] != tlf_pkg::CH_BLANK) brk--;
                if (brk == 0) begin
                    queue_line(fill);
                    fill = 0;
                end else begin
                    rest = fill - (brk + 1);
                    queue_line(brk + 1);
                    for (int i = 0; i < rest; i++) line_buf[i] = line_buf[brk + 1 + i];
                    fill = rest;
                end
            end
        end
        line_fill = 6'(fill);
        if (expected_text.size() > first_new) begin
            tail = expected_text.pop_back();
            tail.last = 1'b1;
            expected_text.push_back(tail);
        end
    endtask

    // s_ driver: predict on accept, then offer the next byte or idle
    always @(posedge i_clk) begin : byte_driver
        logic offer;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) fold_predict(s_tdata);
            if (!s_tvalid || s_tready) begin
                offer = pending_bytes.size() > 0 &&
                        $urandom_range(0, 99) >= send_idle_pct;
                if (offer) begin
                    s_tdata  <= pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // m_ monitor: compare each beat with the oldest expectation
    always @(posedge i_clk) begin : beat_monitor
        t_folded_beat want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                beats_seen++;
                if (expected_text.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("beat %0d unexpected: data %h last %b",
                                 beats_seen, m_tdata, m_tlast);
                end else begin
                    want = expected_text.pop_front();
                    if (m_tdata !== want.ch || m_tlast !== want.last) begin
                        mismatches++;
                        if (mismatches <= SHOWN_ERRORS)
                            $display("beat %0d: expected data %h last %b, %s %h last %b",
                                     beats_seen, want.ch, want.last, "got data",
                                     m_tdata, m_tlast);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog: no beat moving while work is outstanding
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_bytes.size() == 0 && !s_tvalid && expected_text.size() == 0)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d beats outstanding",
                     STALL_LIMIT, expected_text.size());
            $display("FAILED: results differ");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // apb write: setup cycle, then access cycle until pready
    task automatic apb_write(input logic [tlf_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [5:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= tlf_pkg::CFG_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == FOLD_ADDR) cfg_fold = value;
        else cfg_tab = value;
    endtask

    task automatic set_folding(input logic [5:0] fold, input logic [5:0] tab);
        apb_write(FOLD_ADDR, fold);
        apb_write(TAB_ADDR, tab);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
    endtask

    // wait until every byte is taken and every beat checked, then let
    // a byte that produced nothing finish inside the block
    task automatic wait_drained();
        while (pending_bytes.size() > 0 || s_tvalid || expected_text.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly words and blanks, some tabs and newlines, some raw noise
    function automatic logic [7:0] random_char();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)      return 8'($urandom_range(8'h61, 8'h7a));
        else if (pick < 75) return tlf_pkg::CH_BLANK;
        else if (pick < 83) return tlf_pkg::CH_TAB;
        else if (pick < 90) return tlf_pkg::CH_NL;
        else                return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        logic [5:0] fold_set [PHASES];
        logic [5:0] tab_set  [PHASES];
        fold_set = '{6'd20, 6'd2, 6'd32, 6'd8, 6'd12, 6'd1, 6'd63, 6'd16, 6'd5, 6'd33};
        tab_set  = '{6'd6,  6'd1, 6'd32, 6'd4, 6'd0,  6'd63, 6'd3, 6'd8,  6'd2, 6'd7};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: plain text, tab, byte extremes, empty line
        queue_text("ab");
        pending_bytes.push_back(tlf_pkg::CH_TAB);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hff);
        pending_bytes.push_back(tlf_pkg::CH_NL);
        pending_bytes.push_back(tlf_pkg::CH_NL);
        wait_drained();

        // smallest fold, tab width zero, blank only in the first column
        set_folding(6'd2, 6'd0);
        queue_text("xy");
        pending_bytes.push_back(tlf_pkg::CH_TAB);
        pending_bytes.push_back(tlf_pkg::CH_TAB);
        queue_text(" x");
        wait_drained();

        // fold above the buffer size: a tab fills the whole line
        set_folding(6'd63, 6'd63);
        pending_bytes.push_back(tlf_pkg::CH_TAB);
        queue_text("a b");
        wait_drained();

        // fold column lowered below the current fill
        apb_write(FOLD_ADDR, 6'd0);
        queue_text("c");
        pending_bytes.push_back(tlf_pkg::CH_NL);
        wait_drained();

        // fold below minimum with a tab width equal to the buffer depth
        set_folding(6'd1, 6'd32);
        pending_bytes.push_back(tlf_pkg::CH_TAB);
        queue_text("zq");
        wait_drained();

        // random phases across settings and idling modes
        for (int p = 0; p < PHASES; p++) begin
            set_folding(fold_set[p], tab_set[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) pending_bytes.push_back(random_char());
            wait_drained();
        end

        if (expected_text.size() > 0) begin
            mismatches += expected_text.size();
            $display("%0d expected beats never arrived", expected_text.size());
        end
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
